FILE: rtl/core/query_token_scanner_unit_assert.svh
// Assertion macros for the query token scanner checker.
// Each macro needs clk in scope; all but QTS_ASSERT_NEXT_ALWAYS also need rst.
`ifndef QUERY_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define QUERY_TOKEN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QTS_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("query token scanner check failed");

// Next-cycle implication, disabled while reset is high.
`define QTS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("query token scanner check failed");

// Next-cycle implication that is also checked across reset.
`define QTS_ASSERT_NEXT_ALWAYS(label, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("query token scanner check failed");

`endif

FILE: rtl/core/qts_pkg.sv
// Shared types, constants and helpers of the query token scanner.
// No dependencies; imported by every other file but the assertion header.
`default_nettype none

package qts_pkg;

  // A token keeps at most MAX_TOKEN_LEN-1 characters.
  localparam int MAX_TOKEN_LEN = 64;
  localparam logic [7:0] TOKEN_CAP = 8'(MAX_TOKEN_LEN - 1);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_PLUS    = 3'd1,
    MODE_PLAIN   = 3'd2,
    MODE_QUOTE   = 3'd3,
    MODE_BRACKET = 3'd4,
    MODE_QCAP    = 3'd5
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t  mode;
    logic [7:0]  count;
    logic [7:0]  depth;
    logic [7:0]  held_char;
    logic        held_valid;
    logic        plus_seen;
    logic        quote_seen;
    logic        bracket_seen;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    mode: MODE_IDLE, count: 8'd0, depth: 8'd0, held_char: 8'd0,
    held_valid: 1'b0, plus_seen: 1'b0, quote_seen: 1'b0, bracket_seen: 1'b0
  };

  // One result item as it leaves the block.
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_char;
    logic [7:0]  token_length;
    logic        plus_prefix;
    logic        quoted;
    logic        bracketed;
    logic        wildcard_res;
    logic        run_last;
  } res_t;

  // All results of one input item, up to three, in order from entry 0.
  typedef struct packed {
    res_t [2:0]  item;
    logic [1:0]  num;
  } res_list_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_COMMA);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qts_scan.sv
// Scanner state registers and the combinational step logic for one character.
// Depends on qts_pkg for the state, result and character definitions.
`default_nettype none

module qts_scan
  import qts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  logic [7:0]  in_char,
  input  logic        line_end,
  output res_list_t   results
);

  scan_state_t state;
  scan_state_t state_next;

  function automatic void put(inout res_list_t l, input logic kind,
                              input logic [7:0] ch, input logic [7:0] len,
                              input logic pl, input logic qu, input logic br,
                              input logic wc);
    if (l.num < 2'd3) begin
      l.item[l.num] = '{kind: kind, out_char: ch, token_length: len,
                        plus_prefix: pl, quoted: qu, bracketed: br,
                        wildcard_res: wc, run_last: 1'b0};
      l.num = l.num + 2'd1;
    end
  endfunction

  function automatic void close_token(inout scan_state_t s, inout res_list_t l);
    logic [7:0] len;
    logic       wc;
    len = s.count;
    wc  = 1'b0;
    if (s.count != 8'd0) begin
      if (s.held_valid && (s.held_char == CH_STAR)) begin
        // The trailing asterisk is withheld; a lone asterisk is no wildcard.
        len = s.count - 8'd1;
        wc  = (len != 8'd0);
      end else if (s.held_valid) begin
        put(l, KIND_CHAR, s.held_char, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      put(l, KIND_MARKER, CH_NUL, len, s.plus_seen, s.quote_seen,
          s.bracket_seen, wc);
    end
    s = SCAN_CLEAR;
  endfunction

  // Returns 1 when the length cap closed the token instead.
  function automatic logic accept(inout scan_state_t s, inout res_list_t l,
                                  input logic [7:0] c);
    logic was_quote;
    was_quote = (s.mode == MODE_QUOTE);
    if (s.count >= TOKEN_CAP) begin
      close_token(s, l);
      if (was_quote) begin
        s.mode = MODE_QCAP;
      end
      return 1'b1;
    end
    if (s.held_valid) begin
      put(l, KIND_CHAR, s.held_char, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    s.held_char  = c;
    s.held_valid = 1'b1;
    s.count      = s.count + 8'd1;
    return 1'b0;
  endfunction

  function automatic void start_token(inout scan_state_t s, inout res_list_t l,
                                      input logic [7:0] c);
    s.count      = 8'd0;
    s.held_valid = 1'b0;
    s.held_char  = 8'd0;
    if (c == CH_QUOTE) begin
      s.quote_seen = 1'b1;
      s.mode       = MODE_QUOTE;
    end else if (c == CH_OPEN) begin
      s.bracket_seen = 1'b1;
      s.mode         = MODE_BRACKET;
      s.depth        = 8'd1;
      void'(accept(s, l, c));
    end else begin
      s.mode = MODE_PLAIN;
      void'(accept(s, l, c));
    end
  endfunction

  function automatic void take_char(inout scan_state_t s, inout res_list_t l,
                                    input logic [7:0] c);
    logic capped;
    capped = 1'b0;
    case (s.mode)
      MODE_PLUS: begin
        if (is_delim(c)) begin
          s = SCAN_CLEAR;
        end else begin
          start_token(s, l, c);
        end
      end
      MODE_PLAIN: begin
        if (is_delim(c)) begin
          close_token(s, l);
        end else begin
          capped = accept(s, l, c);
        end
      end
      MODE_QUOTE: begin
        if (c == CH_QUOTE) begin
          close_token(s, l);
        end else begin
          capped = accept(s, l, c);
        end
      end
      MODE_BRACKET: begin
        capped = accept(s, l, c);
        if (!capped) begin
          if (c == CH_OPEN) begin
            if (s.depth != 8'hFF) begin
              s.depth = s.depth + 8'd1;
            end
          end else if (c == CH_CLOSE) begin
            if (s.depth != 8'd0) begin
              s.depth = s.depth - 8'd1;
            end
            if (s.depth == 8'd0) begin
              close_token(s, l);
            end
          end
        end
      end
      default: begin
        // Idle, unused codes, and the byte after a capped quoted token.
        // In that last case a closing quote is swallowed.
        if ((s.mode == MODE_QCAP) && (c == CH_QUOTE)) begin
          s.mode = MODE_IDLE;
        end else begin
          s = SCAN_CLEAR;
          if (!is_delim(c)) begin
            if (c == CH_PLUS) begin
              s.plus_seen = 1'b1;
              s.mode      = MODE_PLUS;
            end else begin
              start_token(s, l, c);
            end
          end
        end
      end
    endcase
  endfunction

  always_comb begin
    scan_state_t s;
    res_list_t   l;
    logic        end_of_line;
    s           = state;
    l           = '0;
    end_of_line = line_end || (in_char == CH_NUL);
    if (in_char != CH_NUL) begin
      take_char(s, l, in_char);
    end
    if (end_of_line) begin
      if ((s.mode == MODE_PLAIN) || (s.mode == MODE_QUOTE) ||
          (s.mode == MODE_BRACKET)) begin
        close_token(s, l);
      end else begin
        s = SCAN_CLEAR;
      end
    end
    if (l.num != 2'd0) begin
      l.item[l.num - 2'd1].run_last = 1'b1;
    end
    state_next = s;
    results    = l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_CLEAR;
    end else if (step_en) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/qts_out_buf.sv
// Three-entry result buffer that takes all results of one item at once
// and hands them out one per transfer. Depends on qts_pkg.
`default_nettype none

module qts_out_buf
  import qts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_list_t  load_list,
  output logic       can_load,
  output logic       head_valid,
  input  logic       head_ready,
  output res_t       head
);

  res_t       item [3];
  logic [1:0] num;
  logic       pop;

  assign head_valid = (num != 2'd0);
  assign head       = item[0];
  assign pop        = head_valid && head_ready;
  // Loading is allowed once the buffer is empty or empties in this cycle.
  assign can_load   = (num == 2'd0) || ((num == 2'd1) && head_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      num <= 2'd0;
    end else if (load) begin
      num <= load_list.num;
    end else if (pop) begin
      num <= num - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item[0] <= load_list.item[0];
      item[1] <= load_list.item[1];
      item[2] <= load_list.item[2];
    end else if (pop) begin
      item[0] <= item[1];
      item[1] <= item[2];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/query_token_scanner_unit.sv
// Top level of the query token scanner: input register, scanner, result buffer.
// Depends on qts_pkg, qts_scan and qts_out_buf.
//
// Usage:
//   The slave channel takes one query byte per transfer on s_axis_tdata, with
//   s_axis_tlast marking the last byte of the query; a zero byte also ends it.
//   The master channel gives the token stream: characters (tuser 0) and end
//   markers (tuser 1) that carry the length and the plus, quote, bracket and
//   wildcard flags. m_axis_tlast marks the last result caused by one byte.
//   A byte is held in the input register until the result buffer can take
//   its results; its first result then leaves from the result buffer.
//   Throughput is one byte per cycle as long as each byte yields at most one
//   result and the receiver is ready. A byte that yields k results (up to
//   three, when a token closes) holds the master channel until all k are
//   taken, one per transfer from the result buffer; the next byte waits
//   in the input register meanwhile. A byte with no result is still scanned.
//   When the receiver stalls, the current result holds steady, at most one
//   more byte is taken into the input register, and then s_axis_tready drops.
//   Reset (synchronous, active high) returns the scanner to idle, clears any
//   open token and discards buffered results.
`default_nettype none

module query_token_scanner_unit
  import qts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [15:8] token_length,
                                      // [16] plus_prefix, [17] quoted,
                                      // [18] bracketed, [19] wildcard_res,
                                      // [23:20] zero
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast    // run_last
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_end;
  logic       step;
  logic       can_load;
  res_list_t  results;
  res_t       head;

  // The held byte is scanned as soon as the buffer can take its results.
  assign step          = in_valid && can_load;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  qts_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step),
    .in_char  (in_char),
    .line_end (in_end),
    .results  (results)
  );

  qts_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_list  (results),
    .can_load   (can_load),
    .head_valid (m_axis_tvalid),
    .head_ready (m_axis_tready),
    .head       (head)
  );

  assign m_axis_tdata = {4'b0000, head.wildcard_res, head.bracketed, head.quoted,
                         head.plus_prefix, head.token_length, head.out_char};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.run_last;

endmodule

`default_nettype wire

FILE: rtl/core/qts_checker.sv
// Port-level checks for query_token_scanner_unit, attached by bind.
// Depends on qts_pkg and query_token_scanner_unit_assert.svh.
`default_nettype none

`include "query_token_scanner_unit_assert.svh"

module qts_checker
  import qts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast
);

  logic        char_fields_zero;
  logic        marker_ok;
  logic        input_seen;
  logic        idle_blocked;
  logic [25:0] out_beat;

  // A character carries no length or flags; a marker carries no character and
  // a length no greater than the cap, and a wildcard never comes with length zero.
  assign char_fields_zero = (m_axis_tdata[23:8] == 16'd0);
  assign marker_ok = (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[23:20] == 4'd0) &&
                     (m_axis_tdata[15:8] < TOKEN_CAP + 8'd1) &&
                     (!m_axis_tdata[19] || (m_axis_tdata[15:8] != 8'd0));
  assign input_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'd0);
  assign idle_blocked = !m_axis_tvalid && !input_seen && !s_axis_tready;
  assign out_beat = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `QTS_ASSERT_NEXT_ALWAYS(a_reset_empties, rst, !m_axis_tvalid)
  `QTS_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_beat))
  `QTS_ASSERT_NOW(a_char_clean, m_axis_tvalid && (m_axis_tuser == KIND_CHAR), char_fields_zero)
  `QTS_ASSERT_NOW(a_marker_clean, m_axis_tvalid && (m_axis_tuser == KIND_MARKER), marker_ok)
  `QTS_ASSERT_NEXT(a_no_result_before_input, idle_blocked, !m_axis_tvalid)

endmodule

bind query_token_scanner_unit qts_checker u_qts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for the query token scanner: byte stream in, token stream out.
// Depends on qts_pkg and query_token_scanner_unit; holds its own scanner model.
`timescale 1ns / 100ps

module tb_top;
  import qts_pkg::*;

  // Receiver ready patterns, taken in turn by ready_cyc[9:8].
  localparam logic [1:0] RDY_OPEN   = 2'd0;
  localparam logic [1:0] RDY_COIN   = 2'd1;
  localparam logic [1:0] RDY_SPARSE = 2'd2;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    bit         drain;  // hold this byte back until no result is outstanding
  } query_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  query_byte_t query_q[$];
  query_byte_t next_byte;
  res_t        token_stream_due[$];
  res_t        step_out[$];

  // Scanner state as the model sees it.
  scan_mode_t  sc_mode;
  logic [7:0]  sc_count;
  logic [7:0]  sc_depth;
  logic [7:0]  sc_held;
  logic        sc_held_ok;
  logic        sc_plus;
  logic        sc_quote;
  logic        sc_brk;

  bit          byte_taken = 1'b0;
  int          bytes_in = 0;
  int          bytes_total = 0;
  int          mismatches = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  logic [9:0]  ready_cyc = 10'd0;

  query_token_scanner_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Scanner model. Each accepted byte yields up to three results, which
  // are appended to the due list with the last one flagged.
  // ---------------------------------------------------------------------
  function automatic bit is_sep(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_COMMA;
  endfunction

  function automatic void queue_token_out(logic kind, logic [7:0] ch, logic [7:0] len,
                                          logic pl, logic qu, logic br, logic wc);
    res_t r;
    if (step_out.size() >= 3) return;
    r.kind = kind;
    r.out_char = ch;
    r.token_length = len;
    r.plus_prefix = pl;
    r.quoted = qu;
    r.bracketed = br;
    r.wildcard_res = wc;
    r.run_last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void reset_token();
    sc_mode = MODE_IDLE;
    sc_count = 8'd0;
    sc_depth = 8'd0;
    sc_held = 8'd0;
    sc_held_ok = 1'b0;
    sc_plus = 1'b0;
    sc_quote = 1'b0;
    sc_brk = 1'b0;
  endfunction

  // A held '*' at the end of a token is withheld and turns into the
  // wildcard flag, unless the token was nothing but that asterisk.
  function automatic void finish_token();
    logic [7:0] len;
    logic       wc;
    if (sc_count != 8'd0) begin
      len = sc_count;
      wc = 1'b0;
      if (sc_held_ok && sc_held == CH_STAR) begin
        len = len - 8'd1;
        wc = (len != 8'd0);
      end else if (sc_held_ok) begin
        queue_token_out(KIND_CHAR, sc_held, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      queue_token_out(KIND_MARKER, 8'd0, len, sc_plus, sc_quote, sc_brk, wc);
    end
    reset_token();
  endfunction

  // Returns 1 when the length cap closed the token instead of keeping c.
  function automatic bit keep_char(logic [7:0] c);
    bit was_quote;
    if (sc_count >= TOKEN_CAP) begin
      was_quote = (sc_mode == MODE_QUOTE);
      finish_token();
      if (was_quote) sc_mode = MODE_QCAP;
      return 1'b1;
    end
    if (sc_held_ok) queue_token_out(KIND_CHAR, sc_held, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    sc_held = c;
    sc_held_ok = 1'b1;
    sc_count = sc_count + 8'd1;
    return 1'b0;
  endfunction

  function automatic void open_token(logic [7:0] c);
    sc_count = 8'd0;
    sc_held_ok = 1'b0;
    sc_held = 8'd0;
    if (c == CH_QUOTE) begin
      sc_quote = 1'b1;
      sc_mode = MODE_QUOTE;
    end else if (c == CH_OPEN) begin
      sc_brk = 1'b1;
      sc_mode = MODE_BRACKET;
      sc_depth = 8'd1;
      void'(keep_char(c));
    end else begin
      sc_mode = MODE_PLAIN;
      void'(keep_char(c));
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    case (sc_mode)
      MODE_PLUS: begin
        if (is_sep(c)) reset_token();
        else open_token(c);
      end
      MODE_PLAIN: begin
        if (is_sep(c)) finish_token();
        else void'(keep_char(c));
      end
      MODE_QUOTE: begin
        if (c == CH_QUOTE) finish_token();
        else void'(keep_char(c));
      end
      MODE_BRACKET: begin
        if (!keep_char(c)) begin
          if (c == CH_OPEN) begin
            if (sc_depth != 8'hFF) sc_depth = sc_depth + 8'd1;
          end else if (c == CH_CLOSE) begin
            if (sc_depth != 8'd0) sc_depth = sc_depth - 8'd1;
            if (sc_depth == 8'd0) finish_token();
          end
        end
      end
      default: begin
        // After a capped quoted token, a closing quote right away is swallowed.
        if (sc_mode == MODE_QCAP) begin
          sc_mode = MODE_IDLE;
          if (c == CH_QUOTE) return;
        end
        reset_token();
        if (is_sep(c)) return;
        if (c == CH_PLUS) begin
          sc_plus = 1'b1;
          sc_mode = MODE_PLUS;
          return;
        end
        open_token(c);
      end
    endcase
  endfunction

  function automatic void scan_query_byte(logic [7:0] c, logic eol);
    step_out.delete();
    if (c != CH_NUL) scan_byte(c);
    // A zero byte ends the line just like the line-end flag does.
    if (eol || c == CH_NUL) begin
      if (sc_mode == MODE_PLAIN || sc_mode == MODE_QUOTE || sc_mode == MODE_BRACKET)
        finish_token();
      else
        reset_token();
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i]) token_stream_due.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] c, logic eol = 1'b0, bit drain = 1'b0);
    query_byte_t b;
    b.ch = c;
    b.eol = eol;
    b.drain = drain;
    query_q.push_back(b);
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_COMMA;
    endcase
  endfunction

  // Mostly letters; now and then any byte that does not split a token.
  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'("a") + 8'($urandom_range(0, 25));
    do c = 8'($urandom_range(1, 255)); while (is_sep(c));
    return c;
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  // One query line of random well-formed tokens, mixed with some noise.
  // A quote or bracket group may be left open so that the line end closes it.
  task automatic build_query(input bit drain_first);
    logic [7:0] line[$];
    int         n_tok, pick, len, depth, i, j;
    bit         cut, eol;
    n_tok = $urandom_range(1, 6);
    cut = 1'b0;
    for (i = 0; i < n_tok && !cut; i++) begin
      if (i != 0) repeat ($urandom_range(0, 2)) line.push_back(sep_byte());
      pick = $urandom_range(0, 19);
      if (pick <= 7) begin
        if (pick >= 6) line.push_back(CH_PLUS);
        len = $urandom_range(1, 8);
        repeat (len) line.push_back(word_byte());
        if ($urandom_range(0, 2) == 0) line.push_back(CH_STAR);
      end else if (pick <= 10) begin
        if ($urandom_range(0, 3) == 0) line.push_back(CH_PLUS);
        line.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) line.push_back(quoted_byte());
        if ($urandom_range(0, 5) == 0) cut = 1'b1;
        else line.push_back(CH_QUOTE);
      end else if (pick <= 12) begin
        line.push_back(CH_OPEN);
        depth = 1;
        repeat ($urandom_range(1, 8)) begin
          j = $urandom_range(0, 5);
          if (j == 0 && depth < 3) begin
            line.push_back(CH_OPEN);
            depth++;
          end else if (j == 1 && depth > 1) begin
            line.push_back(CH_CLOSE);
            depth--;
          end else if (j == 2) begin
            line.push_back(sep_byte());
          end else begin
            line.push_back(word_byte());
          end
        end
        if ($urandom_range(0, 5) == 0) cut = 1'b1;
        else repeat (depth) line.push_back(CH_CLOSE);
      end else if (pick == 13) begin
        line.push_back(CH_STAR);
      end else if (pick == 14) begin
        // Token lengths around the cap, in plain, quoted and bracket form.
        j = $urandom_range(0, 2);
        len = $urandom_range(MAX_TOKEN_LEN - 3, MAX_TOKEN_LEN + 2);
        if (j == 1) line.push_back(CH_QUOTE);
        else if (j == 2) line.push_back(CH_OPEN);
        repeat (len) line.push_back(j == 1 ? quoted_byte() : word_byte());
        if (j == 1) line.push_back(CH_QUOTE);
        else if (j == 2) line.push_back(CH_CLOSE);
      end else if (pick == 15) begin
        line.push_back(CH_PLUS);
        line.push_back(sep_byte());
      end else begin
        repeat ($urandom_range(1, 3)) line.push_back(8'($urandom_range(0, 255)));
      end
    end
    j = $urandom_range(0, 3);
    if (j <= 1 || line.size() == 0) line.push_back(CH_NUL);
    eol = (j != 0);
    foreach (line[k]) push_byte(line[k], eol && k == line.size() - 1, drain_first && k == 0);
  endtask

  // ---------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. A byte marked for
  // draining waits until every outstanding result has been seen.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      byte_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (query_q.size() != 0 &&
                   !(query_q[0].drain && token_stream_due.size() != 0)) begin
        next_byte = query_q.pop_front();
        s_axis_tdata  <= next_byte.ch;
        s_axis_tlast  <= next_byte.eol;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: open, coin-flip, sparse and comb-shaped ready patterns in turn.
  always @(negedge clk) begin
    ready_cyc = ready_cyc + 10'd1;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (ready_cyc[9:8])
        RDY_OPEN:   m_axis_tready <= 1'b1;
        RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:    m_axis_tready <= (ready_cyc[2:0] != 3'd0) && (ready_cyc[4:3] != 2'd3);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on each input transfer and checks each output
  // transfer against the oldest due result.
  // ---------------------------------------------------------------------
  task automatic check_token_out();
    res_t        want;
    logic [23:0] want_data;
    if (token_stream_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: tuser=%0d tdata=%h tlast=%0d",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      return;
    end
    want = token_stream_due.pop_front();
    want_data = {4'd0, want.wildcard_res, want.bracketed, want.quoted, want.plus_prefix,
                 want.token_length, want.out_char};
    if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data ||
        m_axis_tlast !== want.run_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: want tuser=%0d tdata=%h tlast=%0d, got tuser=%0d tdata=%h tlast=%0d",
                 want.kind, want_data, want.run_last,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_token();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_query_byte(s_axis_tdata, s_axis_tlast);
        byte_taken = 1'b1;
        bytes_in++;
      end
      if (m_axis_tvalid && m_axis_tready) check_token_out();
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    // Required word with wildcard, empty quotes, nested brackets, lone asterisk.
    push_byte(CH_PLUS); push_byte("a"); push_byte("b"); push_byte(CH_STAR);
    push_byte(CH_COMMA);
    push_byte(CH_QUOTE); push_byte(CH_QUOTE);
    push_byte(CH_OPEN); push_byte("x"); push_byte(CH_OPEN); push_byte(CH_CLOSE);
    push_byte(CH_CLOSE);
    push_byte(CH_STAR); push_byte(CH_TAB);
    // Open quote cut by the line end; delimiters and plus are plain text inside.
    push_byte(CH_QUOTE); push_byte("q"); push_byte(CH_LF); push_byte(8'hFF);
    push_byte(CH_PLUS, 1'b1);
    // Plus before a delimiter, plus pending at line end.
    push_byte(CH_PLUS); push_byte(CH_COMMA); push_byte(CH_PLUS, 1'b1);
    // Plain token ended by a zero byte, bracket left open at line end.
    push_byte("z"); push_byte(CH_NUL);
    push_byte(CH_OPEN); push_byte("k", 1'b1);

    for (int n = 0; query_q.size() < 400; n++) build_query(n % 8 == 0);
    bytes_total = query_q.size();

    wait (bytes_in == bytes_total);
    while (token_stream_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
